@@ rtl/bucketed_hash_table_core_macros.svh @@
//------------------------------------------------------------------------------
// Bucketed hash table assertion macros
// Shared concurrent assertion shorthands.
//------------------------------------------------------------------------------
`ifndef BUCKETED_HASH_TABLE_CORE_MACROS_SVH
`define BUCKETED_HASH_TABLE_CORE_MACROS_SVH

// implication checked on every rising clock edge, skipped during reset
`define BHT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/bht_pkg.sv @@
//------------------------------------------------------------------------------
// Bucketed hash table package
// Shared types and codes for controller and datapath.
//------------------------------------------------------------------------------
package bht_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, start remainder
    logic div_step;  // one restoring step
    logic rd;        // issue row read
    logic commit;    // read-modify-write and form result
  } bht_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
  } bht_sts_t;

endpackage

@@ rtl/bucketed_hash_table_core.sv @@
//------------------------------------------------------------------------------
// Bucketed hash table core
// Key-value table: insert, remove, search by key modulo bucket count.
//------------------------------------------------------------------------------
// Sequence: the input word is taken in idle, then 32 remainder steps, a done
//   state, one row read and one update; the result word is registered and held
//   until accepted. One request at a time: no new word is taken until the
//   result is accepted. Reset clears valid bits, entry count; bucket_count
//   resets to 10.
module bucketed_hash_table_core
  import bht_pkg::*;
#(
  parameter int MAX_BUCKETS      = 16,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[31:0], value[63:32]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // found_value[31:0], entry_count[40:32],
                                     // zero[47:41]
  output logic [2:0]  m_axis_tuser,  // status[2:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i     // bucket_count
);

  logic [4:0] bucket_count_q;
  bht_cmd_t   cmd;
  bht_sts_t   sts;
  logic [2:0]  status;
  logic [31:0] found_value;
  logic [8:0]  entry_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bucket_count_q <= 5'd10;
    else if (cfg_valid_i) bucket_count_q <= cfg_data_i;
  end

  bht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bht_dp #(
    .MAX_BUCKETS     (MAX_BUCKETS),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .bucket_count_i(bucket_count_q),
    .kind_i        (s_axis_tuser),
    .key_i         (s_axis_tdata[31:0]),
    .value_i       (s_axis_tdata[63:32]),
    .status_o      (status),
    .found_value_o (found_value),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = {7'd0, entry_count, found_value};
  assign m_axis_tuser = status;

endmodule

@@ rtl/bht_ctrl.sv @@
//------------------------------------------------------------------------------
// Bucketed hash table controller
// Sequences remainder, row read, update and result handoff.
//------------------------------------------------------------------------------
`include "bucketed_hash_table_core_macros.svh"
module bht_ctrl
  import bht_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  bht_sts_t sts_i,
  output bht_cmd_t cmd_o
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_READ, S_COMMIT, S_OUT} state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_valid_i && (state_q == S_IDLE);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.rd       = (state_q == S_READ);
    cmd_o.commit   = (state_q == S_COMMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DIV;
        end
        S_DIV: begin
          if (sts_i.div_done) state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `BHT_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `BHT_ASSERT_NEXT(a_commit_out, clk_i, rst_ni, cmd_o.commit, out_valid_o)
  `BHT_ASSERT_NEXT(a_load_div, clk_i, rst_ni, cmd_o.load, state_q == S_DIV)

endmodule

@@ rtl/bht_dp.sv @@
//------------------------------------------------------------------------------
// Bucketed hash table datapath
// Bit-serial remainder, bucket row memory, valid bits and entry count.
//------------------------------------------------------------------------------
module bht_dp
  import bht_pkg::*;
#(
  parameter int MAX_BUCKETS      = 16,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bht_cmd_t    cmd_i,
  output bht_sts_t    sts_o,
  input  logic [4:0]  bucket_count_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_value_o,
  output logic [8:0]  entry_count_o
);

  localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int NW  = $clog2(MAX_BUCKETS + 1);
  localparam int RW  = (NW > 5) ? NW : 5;
  localparam int SPB = SLOTS_PER_BUCKET;

  typedef logic [SPB-1:0][31:0] row_t;

  logic [1:0]  kind_q;
  logic [31:0] key_q, value_q, quo_q;
  logic [RW:0] rem_q;
  logic [RW-1:0] div_q;
  logic [5:0]  cnt_q;
  logic [BW-1:0] bkt_q;
  row_t        rkey_q, rval_q;
  row_t        mem_key [MAX_BUCKETS];
  row_t        mem_val [MAX_BUCKETS];
  logic [SPB-1:0] vld_q [MAX_BUCKETS];
  logic [8:0]  entries_q;
  logic [2:0]  status_q;
  logic [31:0] found_q;

  logic [RW-1:0] nb;
  logic [RW:0]   trial;

  always_comb begin
    if (bucket_count_i == 5'd0) nb = RW'(1);
    else if (RW'(bucket_count_i) > RW'(MAX_BUCKETS)) nb = RW'(MAX_BUCKETS);
    else nb = RW'(bucket_count_i);
    trial = {rem_q[RW-1:0], quo_q[31]};
  end

  assign sts_o.div_done = (cnt_q == 6'd32);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
      quo_q   <= key_i;
      rem_q   <= '0;
      div_q   <= nb;
    end else if (cmd_i.div_step && !sts_o.div_done) begin
      quo_q <= {quo_q[30:0], 1'b0};
      if (trial >= {1'b0, div_q}) rem_q <= trial - {1'b0, div_q};
      else rem_q <= trial;
    end
    if (cmd_i.rd) begin
      bkt_q  <= BW'(rem_q);
      rkey_q <= mem_key[BW'(rem_q)];
      rval_q <= mem_val[BW'(rem_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.load) cnt_q <= '0;
    else if (cmd_i.div_step && !sts_o.div_done) cnt_q <= cnt_q + 6'd1;
  end

  logic [SPB-1:0] vrow, hitv, freev;
  logic           hit, free;
  logic [SW-1:0]  hidx, fidx;

  always_comb begin
    vrow = vld_q[bkt_q];
    hit = 1'b0; free = 1'b0; hidx = '0; fidx = '0;
    for (int s = 0; s < SPB; s++) begin
      hitv[s]  = vrow[s] && (rkey_q[s] == key_q);
      freev[s] = !vrow[s];
    end
    for (int s = SPB-1; s >= 0; s--) begin
      if (hitv[s])  begin hit = 1'b1;  hidx = SW'(s); end
      if (freev[s]) begin free = 1'b1; fidx = SW'(s); end
    end
  end

  row_t wkey, wval;
  logic wen;

  always_comb begin
    wkey = rkey_q;
    wval = rval_q;
    wen  = 1'b0;
    if (kind_q == KIND_INSERT) begin
      if (hit) begin
        wval[hidx] = value_q; wen = 1'b1;
      end else if (free) begin
        wkey[fidx] = key_q; wval[fidx] = value_q; wen = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wen) begin
      mem_key[bkt_q] <= wkey;
      mem_val[bkt_q] <= wval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < MAX_BUCKETS; b++) vld_q[b] <= '0;
      entries_q <= '0;
      status_q  <= ST_NOT_FOUND;
      found_q   <= '0;
    end else if (cmd_i.commit) begin
      found_q  <= '0;
      status_q <= ST_NOT_FOUND;
      case (kind_q)
        KIND_INSERT: begin
          if (hit) status_q <= ST_UPDATED;
          else if (free) begin
            status_q <= ST_INSERTED;
            vld_q[bkt_q][fidx] <= 1'b1;
            entries_q <= entries_q + 9'd1;
          end else status_q <= ST_FULL;
        end
        KIND_REMOVE: begin
          if (hit) begin
            status_q <= ST_REMOVED;
            vld_q[bkt_q][hidx] <= 1'b0;
            entries_q <= entries_q - 9'd1;
          end
        end
        KIND_SEARCH: begin
          if (hit) begin
            status_q <= ST_FOUND;
            found_q  <= rval_q[hidx];
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o      = status_q;
  assign found_value_o = found_q;
  assign entry_count_o = entries_q;

endmodule
